### rtl/core/min_separation_point_store_core_assert.svh
// assertion macros for the point store rtl
`ifndef MIN_SEPARATION_POINT_STORE_CORE_ASSERT_SVH
`define MIN_SEPARATION_POINT_STORE_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define MSPSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define MSPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mspsc_pkg.sv
// shared constants and types of the point store core
`timescale 1ns / 1ps

package mspsc_pkg;

   localparam int POINT_SLOTS_DEF  = 256;
   localparam int RECORD_SLOTS_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int FIELD_BITS    = 16;
   localparam int MODE_BITS     = 2;
   localparam int REC_IDX_BITS  = 4;
   localparam int STATUS_BITS   = 2;
   localparam int NEW_REC_BITS  = 4;
   localparam int TOTAL_BITS    = 5;
   localparam int DIST_BITS     = 10;
   localparam int LIMIT_BITS    = 2 * DIST_BITS;
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [DIST_BITS-1:0] MIN_DISTANCE_RESET = 10'd30;

   localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CREATE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_UNDO   = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_CLOSE     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_RECORD = 2'd3;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [NEW_REC_BITS-1:0] new_record;
      logic [TOTAL_BITS-1:0]   record_total;
   } result_type;

   // per-slot outcome of the distance pipeline
   typedef struct packed {
      logic valid;
      logic free;
      logic close;
   } scan_flag_type;

endpackage

### rtl/core/mspsc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module mspsc_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mspsc_dist.sv
// three-stage squared distance pipeline over one stored slot per cycle
`timescale 1ns / 1ps

module mspsc_dist #(
   parameter int  SAMPLE_BITS = mspsc_pkg::SAMPLE_BITS_DEF,
   parameter int  REC_W       = 4,
   localparam int WORD_W      = 1 + REC_W + 3 * SAMPLE_BITS,
   localparam int SQ_W        = 2 * SAMPLE_BITS,
   localparam int SUM_W       = SQ_W + 2,
   localparam int CMP_W       = (SUM_W > mspsc_pkg::LIMIT_BITS) ? SUM_W : mspsc_pkg::LIMIT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [WORD_W-1:0]               rd_word,
   input  logic [3*SAMPLE_BITS-1:0]        target_sample,
   input  logic [REC_W-1:0]                target_rec,
   input  logic [mspsc_pkg::LIMIT_BITS-1:0] limit,
   output mspsc_pkg::scan_flag_type        flags,
   output logic                            busy
);

   localparam int PROD_W = 2 * SAMPLE_BITS + 2;

   // stage 1: per-axis difference
   logic                     v1_ff, match1_ff, free1_ff;
   logic signed [SAMPLE_BITS:0] diff_ff [3];
   logic signed [SAMPLE_BITS:0] diff_in [3];
   // stage 2: per-axis square
   logic                     v2_ff, match2_ff, free2_ff;
   logic [SQ_W-1:0]          sq_ff [3];
   logic [SQ_W-1:0]          sq_in [3];
   logic signed [PROD_W-1:0] prod [3];
   // stage 3: sum and compare
   mspsc_pkg::scan_flag_type flags_ff, flags_in;
   logic [CMP_W-1:0]         sum;

   logic                     word_valid;
   logic [REC_W-1:0]         word_rec;

   assign word_valid = rd_word[WORD_W-1];
   assign word_rec   = rd_word[3*SAMPLE_BITS +: REC_W];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff_in[a] = $signed({target_sample[a*SAMPLE_BITS+SAMPLE_BITS-1],
                               target_sample[a*SAMPLE_BITS +: SAMPLE_BITS]})
                    - $signed({rd_word[a*SAMPLE_BITS+SAMPLE_BITS-1],
                               rd_word[a*SAMPLE_BITS +: SAMPLE_BITS]});
         prod[a]  = PROD_W'(diff_ff[a]) * PROD_W'(diff_ff[a]);
         sq_in[a] = prod[a][SQ_W-1:0];
      end
      sum = CMP_W'(sq_ff[0]) + CMP_W'(sq_ff[1]) + CMP_W'(sq_ff[2]);
      flags_in.valid = v2_ff;
      flags_in.free  = free2_ff;
      flags_in.close = match2_ff && (sum < CMP_W'(limit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         flags_ff.valid <= 1'b0;
      end else begin
         v1_ff          <= in_valid;
         v2_ff          <= v1_ff;
         flags_ff.valid <= flags_in.valid;
      end
      match1_ff      <= word_valid && (word_rec == target_rec);
      free1_ff       <= !word_valid;
      match2_ff      <= match1_ff;
      free2_ff       <= free1_ff;
      flags_ff.free  <= flags_in.free;
      flags_ff.close <= flags_in.close;
      for (int a = 0; a < 3; a++) begin
         diff_ff[a] <= diff_in[a];
         sq_ff[a]   <= sq_in[a];
      end
   end

   assign flags = flags_ff;
   assign busy  = v1_ff || v2_ff || flags_ff.valid;

endmodule

### rtl/core/mspsc_ctrl.sv
// sequencer: clearing pass, scan, undo sweep and result hand-off
`timescale 1ns / 1ps
`include "min_separation_point_store_core_assert.svh"

module mspsc_ctrl #(
   parameter int  POINT_SLOTS  = mspsc_pkg::POINT_SLOTS_DEF,
   parameter int  RECORD_SLOTS = mspsc_pkg::RECORD_SLOTS_DEF,
   parameter int  SAMPLE_BITS  = mspsc_pkg::SAMPLE_BITS_DEF,
   localparam int ADDR_W       = $clog2(POINT_SLOTS),
   localparam int CNT_W        = $clog2(RECORD_SLOTS + 1),
   localparam int REC_W        = $clog2(RECORD_SLOTS),
   localparam int WORD_W       = 1 + REC_W + 3 * SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mspsc_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [mspsc_pkg::REC_IDX_BITS-1:0]    req_rec,
   input  logic [3*SAMPLE_BITS-1:0]              req_sample,
   output logic                                  ram_wr_en,
   output logic [ADDR_W-1:0]                     ram_wr_addr,
   output logic [WORD_W-1:0]                     ram_wr_data,
   output logic                                  ram_rd_en,
   output logic [ADDR_W-1:0]                     ram_rd_addr,
   input  logic [WORD_W-1:0]                     ram_rd_data,
   output logic                                  scan_valid,
   output logic [3*SAMPLE_BITS-1:0]              target_sample,
   output logic [REC_W-1:0]                      target_rec,
   input  mspsc_pkg::scan_flag_type              scan_flags,
   input  logic                                  scan_busy,
   output logic                                  res_valid,
   input  logic                                  res_ready,
   output mspsc_pkg::result_type                 res
);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_DRAIN    = 3'd3;
   localparam logic [2:0] S_UNDO     = 3'd4;
   localparam logic [2:0] S_UNDO_END = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(POINT_SLOTS - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(RECORD_SLOTS);
   localparam int WIDE_W = CNT_W + mspsc_pkg::TOTAL_BITS;

   logic [2:0]                  state_ff, state_in;
   logic [ADDR_W-1:0]           addr_ff, addr_in;
   logic                        scan_rd_ff, scan_rd_in;
   logic                        undo_rd_ff, undo_rd_in;
   logic [ADDR_W-1:0]           rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]           res_idx_ff, res_idx_in;
   logic                        close_ff, close_in;
   logic                        free_found_ff, free_found_in;
   logic [ADDR_W-1:0]           free_addr_ff, free_addr_in;
   logic [REC_W-1:0]            rec_ff, rec_in;
   logic [3*SAMPLE_BITS-1:0]    sample_ff, sample_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [mspsc_pkg::STATUS_BITS-1:0]  status_ff, status_in;
   logic [mspsc_pkg::NEW_REC_BITS-1:0] created_ff, created_in;

   logic [WIDE_W-1:0]           rec_wide;
   logic [WIDE_W-1:0]           cnt_wide;
   logic [REC_W-1:0]            undo_target;

   assign rec_wide    = WIDE_W'(req_rec);
   assign cnt_wide    = WIDE_W'(count_ff);
   assign undo_target = count_ff[REC_W-1:0];

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      scan_rd_in    = 1'b0;
      undo_rd_in    = 1'b0;
      rd_addr_in    = addr_ff;
      res_idx_in    = res_idx_ff;
      close_in      = close_ff;
      free_found_in = free_found_ff;
      free_addr_in  = free_addr_ff;
      rec_in        = rec_ff;
      sample_in     = sample_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      created_in    = created_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = addr_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = addr_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;

      // slot outcomes return in address order, so the first free one is the lowest
      if (scan_flags.valid) begin
         res_idx_in = res_idx_ff + 1'b1;
         if (scan_flags.close) begin
            close_in = 1'b1;
         end
         if (scan_flags.free && !free_found_ff) begin
            free_found_in = 1'b1;
            free_addr_in  = res_idx_ff;
         end
      end

      // undo write-back comes in the cycle after its read, never to the slot then being read
      if (undo_rd_ff && ram_rd_data[WORD_W-1] &&
          (ram_rd_data[3*SAMPLE_BITS +: REC_W] == undo_target)) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = rd_addr_ff;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            addr_in     = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               status_in  = mspsc_pkg::STATUS_OK;
               created_in = '0;
               state_in   = S_FINISH;
               case (req_mode)
                  mspsc_pkg::MODE_ADD: begin
                     if (rec_wide >= cnt_wide) begin
                        status_in = mspsc_pkg::STATUS_NO_RECORD;
                     end else begin
                        rec_in        = rec_wide[REC_W-1:0];
                        sample_in     = req_sample;
                        addr_in       = '0;
                        res_idx_in    = '0;
                        close_in      = 1'b0;
                        free_found_in = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  mspsc_pkg::MODE_CREATE: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = mspsc_pkg::STATUS_FULL;
                     end else begin
                        created_in = cnt_wide[mspsc_pkg::NEW_REC_BITS-1:0];
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  mspsc_pkg::MODE_UNDO: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                        addr_in  = '0;
                        state_in = S_UNDO;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            ram_rd_en  = 1'b1;
            scan_rd_in = 1'b1;
            addr_in    = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!scan_rd_ff && !scan_busy) begin
               state_in = S_FINISH;
               if (close_ff) begin
                  status_in = mspsc_pkg::STATUS_CLOSE;
               end else if (!free_found_ff) begin
                  status_in = mspsc_pkg::STATUS_FULL;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = free_addr_ff;
                  ram_wr_data = {1'b1, rec_ff, sample_ff};
               end
            end
         end
         S_UNDO: begin
            ram_rd_en  = 1'b1;
            undo_rd_in = 1'b1;
            rd_addr_in = addr_ff;
            addr_in    = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = S_UNDO_END;
            end
         end
         S_UNDO_END: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         addr_ff    <= '0;
         scan_rd_ff <= 1'b0;
         undo_rd_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         scan_rd_ff <= scan_rd_in;
         undo_rd_ff <= undo_rd_in;
         count_ff   <= count_in;
      end
      rd_addr_ff    <= rd_addr_in;
      res_idx_ff    <= res_idx_in;
      close_ff      <= close_in;
      free_found_ff <= free_found_in;
      free_addr_ff  <= free_addr_in;
      rec_ff        <= rec_in;
      sample_ff     <= sample_in;
      status_ff     <= status_in;
      created_ff    <= created_in;
   end

   assign scan_valid         = scan_rd_ff;
   assign target_sample      = sample_ff;
   assign target_rec         = rec_ff;
   assign res.status         = status_ff;
   assign res.new_record     = created_ff;
   assign res.record_total   = cnt_wide[mspsc_pkg::TOTAL_BITS-1:0];

   `MSPSC_ASSERT_NOW(a_add_write_ok, clock, reset, (state_ff == S_DRAIN && ram_wr_en), (free_found_ff && !close_ff), "sample stored although too close or no free slot")
   `MSPSC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, (count_ff <= FULL_COUNT), "record count beyond record table")
   `MSPSC_ASSERT_NEXT(a_undo_count, clock, reset, (state_ff == S_IDLE && req_valid && req_mode == mspsc_pkg::MODE_UNDO && count_ff != '0), (count_ff == $past(count_ff) - 1'b1), "undo did not drop the newest record")
   `MSPSC_ASSERT_NOW(a_flags_in_scan, clock, reset, scan_flags.valid, (state_ff == S_SCAN || state_ff == S_DRAIN), "distance result outside a scan")

endmodule

### rtl/core/min_separation_point_store_core.sv
// top level of the magnetometer calibration point store
`timescale 1ns / 1ps

// usage
//   req channel: one transfer is one command; req_tuser is the mode (add sample,
//   create record, undo last record), req_tdata carries the record number and raw x, y, z
//   rsp channel: exactly one transfer per command; rsp_tuser is the status, rsp_tdata
//   carries the created record number and the record count after the command
//   csr channel: writes min_distance; write it only while no command is in flight
// command handling
//   add sample: a sweep over every slot of the store before rsp_tvalid, one ram read per
//   cycle on its single read port
//   create, undo with no records, unknown mode, bad record number: no sweep of the store
//   undo: one read-modify-write sweep of the store
//   one command is worked on at a time; the next is taken once the result has moved
//   into the output register
// reset
//   synchronous; afterwards a clearing pass over every slot marks each one free,
//   req_tready stays low during it while csr writes are still taken
// stalls
//   a result waits in the output register while rsp_tready is low; a further result
//   waits in the sequencer, and no new command is taken until it has moved on

module min_separation_point_store_core #(
   parameter int POINT_SLOTS  = mspsc_pkg::POINT_SLOTS_DEF,
   parameter int RECORD_SLOTS = mspsc_pkg::RECORD_SLOTS_DEF,
   parameter int SAMPLE_BITS  = mspsc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // mode [1:0]
   input  logic [mspsc_pkg::MODE_BITS-1:0]        req_tuser,
   // record_index [3:0], sample_x [19:4], sample_y [35:20], sample_z [51:36], zero [55:52]
   input  logic [mspsc_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // status [1:0]
   output logic [mspsc_pkg::STATUS_BITS-1:0]      rsp_tuser,
   // new_record [3:0], record_total [8:4], zero [15:9]
   output logic [mspsc_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mspsc_pkg::DIST_BITS-1:0]        csr_wdata
);

   localparam int ADDR_W  = $clog2(POINT_SLOTS);
   localparam int REC_W   = $clog2(RECORD_SLOTS);
   localparam int WORD_W  = 1 + REC_W + 3 * SAMPLE_BITS;
   localparam int EXT_W   = mspsc_pkg::FIELD_BITS + SAMPLE_BITS;
   localparam int LIM_W   = mspsc_pkg::LIMIT_BITS;
   localparam int RSP_PAD = mspsc_pkg::RSP_DATA_BITS - mspsc_pkg::NEW_REC_BITS
                            - mspsc_pkg::TOTAL_BITS;

   // configuration register and the squared threshold derived from it
   logic [mspsc_pkg::DIST_BITS-1:0]  min_distance_ff;
   logic [mspsc_pkg::LIMIT_BITS-1:0] limit_ff;

   // samples narrowed or widened to the stored width
   logic [3*SAMPLE_BITS-1:0] req_sample;
   logic [EXT_W-1:0]         ext [3];

   // ram ports
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   // sequencer to distance pipeline
   logic                      scan_valid;
   logic [3*SAMPLE_BITS-1:0]  target_sample;
   logic [REC_W-1:0]          target_rec;
   mspsc_pkg::scan_flag_type  scan_flags;
   logic                      scan_busy;

   // result hand-off and output register
   logic                  res_valid;
   logic                  res_ready;
   mspsc_pkg::result_type res;
   logic                  rsp_valid_ff;
   mspsc_pkg::result_type rsp_res_ff;

   // csr writes are always taken; the square is registered, ready well before a scan uses it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff <= mspsc_pkg::MIN_DISTANCE_RESET;
      end else if (csr_valid) begin
         min_distance_ff <= csr_wdata;
      end
      limit_ff <= LIM_W'(min_distance_ff) * LIM_W'(min_distance_ff);
   end

   // low SAMPLE_BITS of each count, after sign extension from its FIELD_BITS-wide field
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ext[a] = EXT_W'($signed(req_tdata[mspsc_pkg::REC_IDX_BITS + a*mspsc_pkg::FIELD_BITS +:
                                           mspsc_pkg::FIELD_BITS]));
         req_sample[a*SAMPLE_BITS +: SAMPLE_BITS] = ext[a][SAMPLE_BITS-1:0];
      end
   end

   // one word per slot: valid, owning record, z, y, x
   mspsc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (POINT_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mspsc_ctrl #(
      .POINT_SLOTS  (POINT_SLOTS),
      .RECORD_SLOTS (RECORD_SLOTS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_mode      (req_tuser),
      .req_rec       (req_tdata[mspsc_pkg::REC_IDX_BITS-1:0]),
      .req_sample    (req_sample),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .scan_valid    (scan_valid),
      .target_sample (target_sample),
      .target_rec    (target_rec),
      .scan_flags    (scan_flags),
      .scan_busy     (scan_busy),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   mspsc_dist #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .REC_W       (REC_W)
   ) u_dist (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (scan_valid),
      .rd_word       (ram_rd_data),
      .target_sample (target_sample),
      .target_rec    (target_rec),
      .limit         (limit_ff),
      .flags         (scan_flags),
      .busy          (scan_busy)
   );

   // output register: a waiting result does not hold up the sequencer's next command
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_valid && res_ready) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_res_ff.record_total, rsp_res_ff.new_record};

endmodule
